// ----- sv/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants
// Payload structs, register addresses, command codes and the
// controller/datapath interface for the frequency-based cache directory.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int WAYS_DEF        = 8;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    // configuration port
    localparam int          PADDR_W     = 3;
    localparam logic [2:0]  ADDR_WAYS   = 3'd0;
    localparam logic [2:0]  ADDR_POLICY = 3'd4;

    // input command codes
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // replacement policy codes
    localparam logic POLICY_LFU = 1'b0;
    localparam logic POLICY_MFU = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [2:0]  way;
        logic        evicted;
        logic [31:0] evicted_key;
        logic [31:0] hit_total;
        logic [31:0] access_total;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the input transaction
        logic clr;       // clear the store and totals
        logic scan_rd;   // read the way at the index for the scan
        logic upd_hit;   // bump the hit entry
        logic upd_fill;  // fill the free way
        logic swp_rd;    // read the way at the index for the rank sweep
        logic evict;     // overwrite the victim
        logic load_out;  // move the result to the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic found;
        logic has_free;
        logic out_free;
    } t_sts;

endpackage

// ----- sv/lfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfu_ctrl: transaction sequencer
// Steps the way index through the scan and the rank sweep and issues
// datapath commands.
// ----------------------------------------------------------------------------
module lfu_ctrl import lfu_pkg::*; #(
    parameter int WAYS = WAYS_DEF,
    localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_cmd,
    input  logic [WW-1:0] i_last,
    input  t_sts          i_sts,
    output logic          o_stall,
    output t_cmd          o_cmd,
    output logic [WW-1:0] o_idx
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SCAN    = 8'b0000_0010,
        ST_SDRAIN  = 8'b0000_0100,
        ST_UPD     = 8'b0000_1000,
        ST_SWEEP   = 8'b0001_0000,
        ST_SWDRAIN = 8'b0010_0000,
        ST_EVICT   = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [WW-1:0] r_idx, n_idx;
    logic          w_accept;

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    assign o_idx    = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    if (i_in_cmd == CMD_CLEAR) begin
                        o_cmd.clr = 1'b1;
                        n_state   = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_idx         = r_idx + 1'b1;
                if (r_idx == i_last) begin
                    n_state = ST_SDRAIN;
                end
            end
            ST_SDRAIN: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                n_idx = '0;
                if (i_sts.found) begin
                    o_cmd.upd_hit = 1'b1;
                    n_state       = ST_DONE;
                end else if (i_sts.has_free) begin
                    o_cmd.upd_fill = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                o_cmd.swp_rd = 1'b1;
                n_idx        = r_idx + 1'b1;
                if (r_idx == i_last) begin
                    n_state = ST_SWDRAIN;
                end
            end
            ST_SWDRAIN: begin
                n_state = ST_EVICT;
            end
            ST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ----- sv/lfu_dp.sv -----
// ----------------------------------------------------------------------------
// lfu_dp: directory datapath
// Key, count and rank memories, valid flags, scan and victim registers,
// totals and the output register.
// ----------------------------------------------------------------------------
module lfu_dp import lfu_pkg::*; #(
    parameter int WAYS        = WAYS_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    localparam int WW         = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [WW-1:0] i_idx,
    input  logic [WW-1:0] i_last,
    input  logic          i_policy,
    input  t_in_item      i_data,
    output t_sts          o_sts,
    output t_out_item     o_data,
    output logic          o_valid,
    input  logic          i_stall
);

    logic [KEY_WIDTH-1:0]   mem_key  [WAYS];
    logic [COUNT_WIDTH-1:0] mem_cnt  [WAYS];
    logic [WW-1:0]          mem_rank [WAYS];

    logic [KEY_WIDTH-1:0]   r_rd_key;
    logic [COUNT_WIDTH-1:0] r_rd_cnt;
    logic [WW-1:0]          r_rd_rank;

    logic [WAYS-1:0]        r_valid;
    logic [KEY_WIDTH-1:0]   r_key;
    logic                   r_ev_vld, r_sw_vld;
    logic [WW-1:0]          r_ev_idx, r_sw_idx;

    logic                   r_found, r_has_free;
    logic [WW-1:0]          r_hidx, r_fidx, r_vidx, r_vrank;
    logic [COUNT_WIDTH-1:0] r_hcnt, r_vcnt;
    logic [KEY_WIDTH-1:0]   r_vkey;
    logic [WW:0]            r_used;

    logic [31:0]            r_hits, r_accs;
    logic                   r_res_hit, r_res_ev;
    logic [WW-1:0]          r_res_way;
    logic [KEY_WIDTH-1:0]   r_res_evk;

    t_out_item              r_out;
    logic                   r_out_vld;

    logic [63:0]            w_key64, w_evk64, w_way64;
    logic [KEY_WIDTH-1:0]   w_key;
    logic                   w_better;
    logic [COUNT_WIDTH-1:0] w_hcnt_inc;
    logic                   w_out_free;

    assign w_key64 = {32'd0, i_data.key};
    assign w_key   = w_key64[KEY_WIDTH-1:0];
    assign w_evk64 = 64'(r_res_evk);
    assign w_way64 = 64'(r_res_way);

    // victim order: ties fall to the older rank
    always_comb begin
        if (r_rd_cnt == r_vcnt) begin
            w_better = (r_rd_rank < r_vrank);
        end else if (i_policy == POLICY_LFU) begin
            w_better = (r_rd_cnt < r_vcnt);
        end else begin
            w_better = (r_rd_cnt > r_vcnt);
        end
    end

    assign w_hcnt_inc = (&r_hcnt) ? r_hcnt : r_hcnt + 1'b1;
    assign w_out_free = !r_out_vld || !i_stall;

    assign o_sts.found    = r_found;
    assign o_sts.has_free = r_has_free;
    assign o_sts.out_free = w_out_free;
    assign o_data         = r_out;
    assign o_valid        = r_out_vld;

    // memories: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        r_rd_key  <= mem_key[i_idx];
        r_rd_cnt  <= mem_cnt[i_idx];
        r_rd_rank <= mem_rank[i_idx];
        if (i_cmd.upd_hit) begin
            mem_cnt[r_hidx] <= w_hcnt_inc;
        end else if (i_cmd.upd_fill) begin
            mem_key[r_fidx]  <= r_key;
            mem_cnt[r_fidx]  <= COUNT_WIDTH'(1);
            mem_rank[r_fidx] <= r_used[WW-1:0];
        end else if (i_cmd.evict) begin
            mem_key[r_vidx]  <= r_key;
            mem_cnt[r_vidx]  <= COUNT_WIDTH'(1);
            mem_rank[r_vidx] <= i_last;
        end else if (r_sw_vld && r_valid[r_sw_idx] && (r_rd_rank > r_vrank)) begin
            mem_rank[r_sw_idx] <= r_rd_rank - 1'b1;
        end
    end

    // scan evaluation and result registers
    always_ff @(posedge i_clk) begin
        r_ev_idx <= i_idx;
        r_sw_idx <= i_idx;
        if (i_cmd.load) begin
            r_key      <= w_key;
            r_found    <= 1'b0;
            r_has_free <= 1'b0;
            r_used     <= '0;
            r_res_hit  <= 1'b0;
            r_res_ev   <= 1'b0;
            r_res_way  <= '0;
            r_res_evk  <= '0;
        end
        if (r_ev_vld) begin
            if (r_valid[r_ev_idx]) begin
                r_used <= r_used + 1'b1;
                if (!r_found && (r_rd_key == r_key)) begin
                    r_found <= 1'b1;
                    r_hidx  <= r_ev_idx;
                    r_hcnt  <= r_rd_cnt;
                end
            end else if (!r_has_free) begin
                r_has_free <= 1'b1;
                r_fidx     <= r_ev_idx;
            end
            if ((r_ev_idx == '0) || w_better) begin
                r_vidx  <= r_ev_idx;
                r_vcnt  <= r_rd_cnt;
                r_vrank <= r_rd_rank;
                r_vkey  <= r_rd_key;
            end
        end
        if (i_cmd.upd_hit) begin
            r_res_hit <= 1'b1;
            r_res_way <= r_hidx;
        end
        if (i_cmd.upd_fill) begin
            r_res_way <= r_fidx;
        end
        if (i_cmd.evict) begin
            r_res_ev  <= 1'b1;
            r_res_evk <= r_vkey;
            r_res_way <= r_vidx;
        end
        if (i_cmd.load_out) begin
            r_out.hit          <= r_res_hit;
            r_out.way          <= w_way64[2:0];
            r_out.evicted      <= r_res_ev;
            r_out.evicted_key  <= w_evk64[31:0];
            r_out.hit_total    <= r_hits;
            r_out.access_total <= r_accs;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_hits    <= '0;
            r_accs    <= '0;
            r_ev_vld  <= 1'b0;
            r_sw_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_ev_vld <= i_cmd.scan_rd;
            r_sw_vld <= i_cmd.swp_rd;
            if (i_cmd.clr) begin
                r_valid <= '0;
                r_hits  <= '0;
                r_accs  <= '0;
            end else if (i_cmd.load && (r_accs != '1)) begin
                r_accs <= r_accs + 1'b1;
            end
            if (i_cmd.upd_hit && (r_hits != '1)) begin
                r_hits <= r_hits + 1'b1;
            end
            if (i_cmd.upd_fill) begin
                r_valid[r_fidx] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/lfu_mfu_cache_replacement.sv -----
// ----------------------------------------------------------------------------
// lfu_mfu_cache_replacement: frequency-based cache directory
// Fully associative directory with least- or most-frequently-used
// replacement, oldest insertion breaking ties, and hit/access totals.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_data  (t_in_item)
//  result    out        o_valid / i_stall    o_data  (t_out_item)
//  config    in         psel/penable/pwrite  paddr, pwdata, prdata
//
// sequence: with n active ways, a hit or a fill follows a scan of the n ways, an
//   eviction a scan and then a rank sweep; a clear skips both. the scan and the
//   rank sweep go one way per cycle over the memories
// one transaction is in flight at a time; o_stall is high until the result
//   is loaded into the output register, which may still be held by i_stall
// reset clears the valid flags and the totals and sets the configuration to eight ways, LFU
//
module lfu_mfu_cache_replacement import lfu_pkg::*; #(
    parameter int WAYS        = WAYS_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in_item           i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out_item          o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [3:0]    r_ways;
    logic          r_policy;
    logic [WW-1:0] w_last;
    logic [31:0]   w_ways32;
    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [WW-1:0] w_idx;

    // configuration registers, written in the apb access phase
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways   <= 4'd8;
            r_policy <= POLICY_LFU;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_WAYS:   r_ways   <= pwdata[3:0];
                ADDR_POLICY: r_policy <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_WAYS:   prdata = {28'd0, r_ways};
            ADDR_POLICY: prdata = {31'd0, r_policy};
            default:     prdata = '0;
        endcase
    end

    // last active way: zero acts as one, anything above WAYS as WAYS
    assign w_ways32 = 32'(r_ways);
    always_comb begin
        if (w_ways32 == 32'd0) begin
            w_last = '0;
        end else if (w_ways32 > 32'(WAYS)) begin
            w_last = WW'(WAYS - 1);
        end else begin
            w_last = WW'(w_ways32 - 32'd1);
        end
    end

    // sequencer: scan, decide, sweep ranks on eviction
    lfu_ctrl #(
        .WAYS (WAYS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_cmd   (i_data.cmd),
        .i_last     (w_last),
        .i_sts      (w_sts),
        .o_stall    (o_stall),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    // directory storage and result path
    lfu_dp #(
        .WAYS        (WAYS),
        .KEY_WIDTH   (KEY_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_idx    (w_idx),
        .i_last   (w_last),
        .i_policy (r_policy),
        .i_data   (i_data),
        .o_sts    (w_sts),
        .o_data   (o_data),
        .o_valid  (o_valid),
        .i_stall  (i_stall)
    );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for the frequency-based cache directory
// Drives access and clear transactions with random gaps and result-side
// stalls, and predicts every result with its own model of the directory.
// Results are checked field by field, in order, against that model.
// It runs through several way counts and both replacement policies.
// ----------------------------------------------------------------------------
module tb;
    import lfu_pkg::*;

    localparam int NUM_WAYS   = WAYS_DEF;
    localparam int COUNT_MAX  = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int STALL_LIMIT = 3000;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    t_in_item           i_data  = '0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic               o_stall;
    logic               o_valid;
    t_out_item          o_data;
    logic [31:0]        prdata;
    logic               pready;

    lfu_mfu_cache_replacement u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // transactions waiting to be sent, and lookups whose results are due
    t_in_item  pending_q[$];
    t_out_item lookup_q[$];
    int        errors  = 0;
    bit        no_idle = 1'b0;   // stretch with no gaps and no stalls
    int        quiet_cycles = 0;

    // our own copy of the directory
    logic [31:0] dir_key[NUM_WAYS];
    bit          dir_valid[NUM_WAYS];
    int          dir_count[NUM_WAYS];
    int          dir_rank[NUM_WAYS];
    logic [31:0] hits_run;
    logic [31:0] access_run;
    logic [3:0]  cfg_ways;
    logic        cfg_policy;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // one lookup or clear against the directory copy, giving the result
    function automatic t_out_item cache_lookup(t_in_item it);
        t_out_item r;
        int        n, used, free_way, v, vr;
        bit        found, has_free, better;
        r = '0;
        n = (cfg_ways == 0) ? 1 : ((cfg_ways > NUM_WAYS) ? NUM_WAYS : int'(cfg_ways));
        if (it.cmd == CMD_CLEAR) begin
            foreach (dir_valid[i]) dir_valid[i] = 1'b0;
            hits_run   = '0;
            access_run = '0;
        end else begin
            found = 0; has_free = 0; used = 0; free_way = 0;
            if (access_run != 32'hFFFF_FFFF) access_run++;
            for (int i = 0; i < n; i++) begin
                if (dir_valid[i]) begin
                    used++;
                    if (!found && dir_key[i] == it.key) begin
                        found = 1;
                        r.way = i[2:0];
                    end
                end else if (!has_free) begin
                    has_free = 1;
                    free_way = i;
                end
            end
            if (found) begin
                r.hit = 1'b1;
                if (hits_run != 32'hFFFF_FFFF) hits_run++;
                if (dir_count[r.way] < COUNT_MAX) dir_count[r.way]++;
            end else if (has_free) begin
                r.way = free_way[2:0];
                dir_valid[free_way] = 1'b1;
                dir_key[free_way]   = it.key;
                dir_count[free_way] = 1;
                dir_rank[free_way]  = used;
            end else begin
                // victim search: count decides, oldest rank breaks ties
                v = 0;
                for (int i = 1; i < n; i++) begin
                    if (dir_count[i] == dir_count[v])
                        better = dir_rank[i] < dir_rank[v];
                    else if (cfg_policy == POLICY_LFU)
                        better = dir_count[i] < dir_count[v];
                    else
                        better = dir_count[i] > dir_count[v];
                    if (better) v = i;
                end
                vr = dir_rank[v];
                for (int i = 0; i < n; i++)
                    if (dir_valid[i] && dir_rank[i] > vr) dir_rank[i]--;
                r.way         = v[2:0];
                r.evicted     = 1'b1;
                r.evicted_key = dir_key[v];
                dir_key[v]    = it.key;
                dir_count[v]  = 1;
                dir_rank[v]   = n - 1;
            end
        end
        r.hit_total    = hits_run;
        r.access_total = access_run;
        return r;
    endfunction

    // driver: feeds the input channel from the pending queue
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                lookup_q.push_back(cache_lookup(i_data));
            if (!i_valid || !o_stall) begin
                if (pending_q.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
                    i_valid <= 1'b1;
                    i_data  <= pending_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result and stalls at random
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (lookup_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", o_data);
                end else begin
                    want = lookup_q.pop_front();
                    if (o_data.hit !== want.hit || o_data.way !== want.way ||
                        o_data.evicted !== want.evicted ||
                        o_data.evicted_key !== want.evicted_key ||
                        o_data.hit_total !== want.hit_total ||
                        o_data.access_total !== want.access_total) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p actual %p", want, o_data);
                    end
                end
            end
            i_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 30);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WAYS) cfg_ways = value[3:0];
        else if (addr == ADDR_POLICY) cfg_policy = value[0];
    endtask

    // wait until every transaction is sent and every result is back
    task automatic drain();
        while (pending_q.size() != 0 || lookup_q.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic queue_item(input logic cmd, input logic [31:0] key);
        t_in_item it;
        it.cmd = cmd;
        it.key = key;
        pending_q.push_back(it);
    endtask

    // mostly keys from a small working set so that hits and evictions occur
    task automatic queue_random(input int count);
        logic [31:0] pool[16];
        int          pool_n, r;
        pool_n = $urandom_range(3, 14);
        foreach (pool[i]) pool[i] = $urandom();
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 2) queue_item(CMD_CLEAR, $urandom());
            else if (r < 12) queue_item(CMD_ACCESS, $urandom());
            else queue_item(CMD_ACCESS, pool[$urandom_range(0, pool_n - 1)]);
        end
    endtask

    initial begin
        int          ways_seq[10]   = '{8, 8, 1, 0, 15, 3, 5, 2, 8, 6};
        logic        policy_seq[10] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                        1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        foreach (dir_valid[i]) dir_valid[i] = 1'b0;
        hits_run   = '0;
        access_run = '0;
        cfg_ways   = 4'd8;
        cfg_policy = POLICY_LFU;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme keys, fill to full, hits, LFU eviction, clear
        reg_write(ADDR_WAYS, 32'd8);
        reg_write(ADDR_POLICY, 32'(POLICY_LFU));
        queue_item(CMD_ACCESS, 32'h0000_0000);
        queue_item(CMD_ACCESS, 32'hFFFF_FFFF);
        queue_item(CMD_ACCESS, 32'h0000_0000);
        for (int k = 1; k <= 6; k++) queue_item(CMD_ACCESS, k);
        queue_item(CMD_ACCESS, 32'hFFFF_FFFF);
        queue_item(CMD_ACCESS, 32'h1234_5678);   // full: evicts the oldest count-1 entry
        queue_item(CMD_ACCESS, 32'hAAAA_5555);
        queue_item(CMD_ACCESS, 32'h5555_AAAA);
        queue_item(CMD_ACCESS, 32'h0000_0003);
        queue_item(CMD_CLEAR,  32'hFFFF_FFFF);
        queue_item(CMD_ACCESS, 32'hFFFF_FFFF);
        drain();

        // directed: most-used eviction, then shrink with live entries outside
        reg_write(ADDR_POLICY, 32'(POLICY_MFU));
        for (int k = 0; k < 8; k++) queue_item(CMD_ACCESS, 32'h100 + k);
        queue_item(CMD_ACCESS, 32'h0000_0105);
        queue_item(CMD_ACCESS, 32'h0000_0200);   // evicts the busiest entry
        drain();
        reg_write(ADDR_WAYS, 32'd2);
        queue_item(CMD_ACCESS, 32'h0000_0107);   // lives in way 0, still active: hit
        queue_item(CMD_ACCESS, 32'h0000_0300);
        drain();

        // random phases over way counts and policies, rarely cleared between
        for (int p = 0; p < 10; p++) begin
            reg_write(ADDR_WAYS, ways_seq[p]);
            reg_write(ADDR_POLICY, 32'(policy_seq[p]));
            no_idle = (p == 6);
            queue_random(160);
            drain();
        end
        no_idle = 1'b0;

        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
